// ===== rtl/core/ffba_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ffba_pkg;
    localparam int MAX_BLOCKS = 32;
    localparam int ADDR_BITS  = 16;
    localparam int SIZE_BITS  = ADDR_BITS + 1;
    localparam int CNT_BITS   = $clog2(MAX_BLOCKS + 1);
    localparam int IDX_BITS   = $clog2(MAX_BLOCKS);
    localparam logic [SIZE_BITS-1:0] MEM_LIMIT = SIZE_BITS'(1) << ADDR_BITS;

    typedef enum logic [1:0] {
        REQ_ALLOC = 2'd0,
        REQ_FREE  = 2'd1,
        REQ_CHECK = 2'd2,
        REQ_NONE  = 2'd3
    } req_type_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NO_SPACE   = 3'd1,
        ST_TABLE_FULL = 3'd2,
        ST_NOT_FOUND  = 3'd3,
        ST_OUTSIDE    = 3'd4,
        ST_ZERO_SIZE  = 3'd5
    } status_t;

    // Internal marker: scan has not decided yet.
    localparam logic [2:0] ST_PENDING = 3'd7;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } fsm_state_t;

    // Shift command broadcast to all cells.
    typedef enum logic [1:0] {
        SH_HOLD,
        SH_UP,    // cell i takes cell i-1 for i > pos, cell pos loads new
        SH_DOWN   // cell i takes cell i+1 for i >= pos
    } shift_op_t;

    typedef struct packed {
        logic [1:0]           req_type;
        logic [SIZE_BITS-1:0] alloc_size;
        logic [ADDR_BITS-1:0] target_address;
        logic [2:0]           access_bytes;
    } req_t;

    typedef struct packed {
        logic [2:0]           status;
        logic [ADDR_BITS-1:0] block_address;
        logic [SIZE_BITS-1:0] free_bytes;
        logic [CNT_BITS-1:0]  blocks_in_use;
    } rsp_t;

    // Data handed from cell to cell.
    typedef struct packed {
        logic [ADDR_BITS-1:0] start;
        logic [SIZE_BITS-1:0] length;
    } entry_t;

    typedef struct packed {
        shift_op_t            op;
        logic [IDX_BITS-1:0]  pos;
        entry_t               load;
    } shift_cmd_t;
endpackage
`default_nettype wire

// ===== rtl/core/ffba_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ffba_cell import ffba_pkg::*; (
    input  wire logic                aclk,
    input  wire logic [IDX_BITS-1:0] my_idx,
    input  wire shift_cmd_t          cmd,
    input  wire entry_t              from_lo,
    input  wire entry_t              from_hi,
    output entry_t                   entry_q
);
    entry_t entry_reg, entry_next;

    always_comb begin
        entry_next = entry_reg;
        case (cmd.op)
            SH_UP: begin
                if (my_idx == cmd.pos) begin
                    entry_next = cmd.load;
                end else if (my_idx > cmd.pos) begin
                    entry_next = from_lo;
                end
            end
            SH_DOWN: begin
                if (my_idx >= cmd.pos) begin
                    entry_next = from_hi;
                end
            end
            default: entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry_q = entry_reg;
endmodule
`default_nettype wire

// ===== rtl/core/ffba_chain.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ffba_chain import ffba_pkg::*; (
    input  wire logic                   aclk,
    input  wire shift_cmd_t             cmd,
    input  wire logic [IDX_BITS-1:0]    rd_idx,
    output entry_t                      rd_entry
);
    entry_t cells_q [MAX_BLOCKS];

    for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
        entry_t lo_in, hi_in;
        if (i == 0) begin : g_lo0
            assign lo_in = cells_q[0];
        end else begin : g_lo
            assign lo_in = cells_q[i-1];
        end
        if (i == MAX_BLOCKS - 1) begin : g_hiN
            assign hi_in = cells_q[i];
        end else begin : g_hi
            assign hi_in = cells_q[i+1];
        end
        ffba_cell u_cell (
            .aclk    (aclk),
            .my_idx  (IDX_BITS'(i)),
            .cmd     (cmd),
            .from_lo (lo_in),
            .from_hi (hi_in),
            .entry_q (cells_q[i])
        );
    end

    assign rd_entry = cells_q[rd_idx];
endmodule
`default_nettype wire

// ===== rtl/core/first_fit_block_allocator_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// First-fit block allocator. A row of MAX_BLOCKS cells holds the allocated
// blocks (start, length) sorted by start; an insert or a remove moves every
// cell above the chosen slot by one place with one shift command. Each request
// is handled alone: it is latched, the scan walks the table entry by entry
// up to the end of the block list for an allocate, free or check, a successful
// allocate or free then updates the table, and the result is presented.
// The result register holds the answer until taken; the next request may be
// accepted meanwhile, but its result is presented only once the previous one
// has been taken. A memory size in cfg_data above 2^ADDR_BITS is clipped.
module first_fit_block_allocator_core import ffba_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire req_t                 s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output rsp_t                      m_data,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [SIZE_BITS-1:0] cfg_data
);
    fsm_state_t state_reg, state_next;
    req_t                 req_reg;
    logic [SIZE_BITS-1:0] mem_reg;
    logic [CNT_BITS-1:0]  count_reg, count_next;
    logic [SIZE_BITS-1:0] used_reg, used_next;
    logic [CNT_BITS-1:0]  idx_reg, idx_next;
    logic [ADDR_BITS:0]   prev_end_reg, prev_end_next;   // end of entry idx-1
    logic [2:0]           status_reg, status_next;
    logic [ADDR_BITS-1:0] addr_reg, addr_next;
    logic                 shift_reg, shift_next;          // table update pending
    shift_cmd_t           cmd;
    entry_t               rd_entry;
    rsp_t                 rsp_reg;
    logic                 m_valid_reg;

    logic [SIZE_BITS-1:0] mem_eff;
    logic [ADDR_BITS:0]   gap_hi, cur_end;
    logic [ADDR_BITS+1:0] lo_plus;
    logic                 at_end;

    assign mem_eff   = (mem_reg > MEM_LIMIT) ? MEM_LIMIT : mem_reg;
    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = rsp_reg;

    ffba_chain u_chain (
        .aclk     (aclk),
        .cmd      (cmd),
        .rd_idx   (idx_reg[IDX_BITS-1:0]),
        .rd_entry (rd_entry)
    );

    assign at_end  = (idx_reg == count_reg);
    assign gap_hi  = at_end ? (ADDR_BITS+1)'(mem_eff) : {1'b0, rd_entry.start};
    assign cur_end = (ADDR_BITS+1)'({1'b0, rd_entry.start}) +
                     (ADDR_BITS+1)'(rd_entry.length);
    assign lo_plus = (ADDR_BITS+2)'(prev_end_reg) + (ADDR_BITS+2)'(req_reg.alloc_size);

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (s_valid) state_next = S_SCAN;
            S_SCAN: begin
                if (status_next != status_reg || idx_next == idx_reg) begin
                    state_next = shift_next ? S_SHIFT : S_DONE;
                end
            end
            S_SHIFT: state_next = S_DONE;
            S_DONE:  if (!m_valid_reg || m_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Scan step and datapath.
    always_comb begin
        idx_next      = idx_reg;
        prev_end_next = prev_end_reg;
        status_next   = status_reg;
        addr_next     = addr_reg;
        shift_next    = shift_reg;
        count_next    = count_reg;
        used_next     = used_reg;
        cmd.op        = SH_HOLD;
        cmd.pos       = idx_reg[IDX_BITS-1:0];
        cmd.load.start  = addr_reg;
        cmd.load.length = req_reg.alloc_size;
        case (state_reg)
            S_SCAN: begin
                case (req_reg.req_type)
                    REQ_ALLOC: begin
                        if (req_reg.alloc_size == '0) begin
                            status_next = ST_ZERO_SIZE;
                        end else if (count_reg == CNT_BITS'(MAX_BLOCKS)) begin
                            status_next = ST_TABLE_FULL;
                        end else if (gap_hi >= prev_end_reg &&
                                     (ADDR_BITS+2)'(gap_hi) >= lo_plus &&
                                     lo_plus <= (ADDR_BITS+2)'(mem_eff)) begin
                            status_next = ST_OK;
                            addr_next   = prev_end_reg[ADDR_BITS-1:0];
                            shift_next  = 1'b1;
                        end else if (at_end) begin
                            status_next = ST_NO_SPACE;
                        end else begin
                            idx_next      = idx_reg + 1'b1;
                            prev_end_next = cur_end;
                        end
                    end
                    REQ_FREE: begin
                        if (at_end) begin
                            status_next = ST_NOT_FOUND;
                        end else if (rd_entry.start == req_reg.target_address) begin
                            status_next = ST_OK;
                            shift_next  = 1'b1;
                        end else begin
                            idx_next = idx_reg + 1'b1;
                        end
                    end
                    REQ_CHECK: begin
                        if (req_reg.access_bytes == '0 || at_end) begin
                            status_next = ST_OUTSIDE;
                        end else if (req_reg.target_address >= rd_entry.start &&
                                     (ADDR_BITS+1)'(req_reg.target_address) +
                                     (ADDR_BITS+1)'(req_reg.access_bytes) <= cur_end) begin
                            status_next = ST_OK;
                        end else begin
                            idx_next = idx_reg + 1'b1;
                        end
                    end
                    default: status_next = ST_OK;
                endcase
            end
            S_SHIFT: begin
                shift_next = 1'b0;
                if (req_reg.req_type == REQ_ALLOC) begin
                    cmd.op     = SH_UP;
                    count_next = count_reg + 1'b1;
                    used_next  = used_reg + req_reg.alloc_size;
                end else begin
                    cmd.op     = SH_DOWN;
                    count_next = count_reg - 1'b1;
                    used_next  = used_reg - rd_entry.length;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            mem_reg     <= SIZE_BITS'(65536);
            count_reg   <= '0;
            used_reg    <= '0;
            m_valid_reg <= 1'b0;
            shift_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            used_reg  <= used_next;
            shift_reg <= shift_next;
            if (cfg_valid && cfg_ready) mem_reg <= cfg_data;
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            // Present result once the previous one is gone.
            if (state_reg == S_DONE && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        prev_end_reg <= prev_end_next;
        status_reg   <= status_next;
        addr_reg     <= addr_next;
        if (state_reg == S_IDLE && s_valid) begin
            req_reg      <= s_data;
            idx_reg      <= '0;
            prev_end_reg <= '0;
            status_reg   <= ST_PENDING;    // scan still open
            addr_reg     <= '0;
        end
        if (state_reg == S_DONE && (!m_valid_reg || m_ready)) begin
            rsp_reg.status        <= status_reg;
            rsp_reg.block_address <= (status_reg == ST_OK &&
                                      req_reg.req_type == REQ_ALLOC) ? addr_reg : '0;
            rsp_reg.free_bytes    <= (mem_eff > used_reg) ? mem_eff - used_reg : '0;
            rsp_reg.blocks_in_use <= count_reg;
        end
    end

    ast_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_BITS'(MAX_BLOCKS))
        else $error("block count exceeds table depth");
    ast_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != S_SHIFT |=> $past(count_reg) == count_reg)
        else $error("block count changed outside update");
    ast_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != S_IDLE |-> !s_ready)
        else $error("request accepted while busy");
endmodule
`default_nettype wire
